// ===== sv/efm_pkg.sv =====
`default_nettype none
package efm_pkg;

	localparam int MAX_EXPOSURES_DEF = 4;
	localparam int SAMPLE_BITS_DEF   = 10;
	localparam int ITEM_LANES        = 4;
	localparam int WEIGHT_BITS       = 16;
	localparam int VALUE_BITS        = 10;
	localparam int CFG_BITS          = 3;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 3'd4;
	localparam int SERIES_TERMS      = 13;
	localparam logic [63:0] Q31_ONE  = 64'd1 << 31;

	// Well-exposedness weight exp(-12.5*(v-0.5)^2) as a fraction over 65535.
	// Evaluated only at elaboration to fill the weight ROM. The exponential is
	// taken as a truncated series at x/8 and then squared three times.
	function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [63:0] s,
			input int sample_bits);
		logic [63:0] half;
		logic [63:0] d;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] e;
		int sh;
		half = 64'd1 << (sample_bits - 1);
		d = (s >= half) ? (s - half) : (half - s);
		x = 64'd25 * d * d;
		sh = 30 - 2 * sample_bits;
		if (sh >= 0) begin
			x = x << sh;
		end else begin
			x = x >> (-sh);
		end
		y = x >> 3;
		e = Q31_ONE;
		term = Q31_ONE;
		for (int k = 1; k <= SERIES_TERMS; k++) begin
			term = ((term * y) >> 31) / 64'(k);
			if ((k & 1) != 0) begin
				e = (e >= term) ? (e - term) : 64'd0;
			end else begin
				e = e + term;
			end
		end
		for (int i = 0; i < 3; i++) begin
			e = (e * e) >> 31;
		end
		return WEIGHT_BITS'((e * 64'd65535 + (64'd1 << 30)) >> 31);
	endfunction

endpackage
`default_nettype wire

// ===== sv/exposure_fusion_merge_unit.sv =====
// Exposure fusion merge unit.
// Input stream s_axis: one beat per pixel carries the samples of exposures 0 to 3
// in tdata and the last-pixel flag in tlast. Output stream m_axis: one beat per
// pixel carries the merged value in tdata and the copied flag in tlast.
// The configuration write port (cfg_wen, cfg_wdata) sets how many exposures take
// part; values above the lane count saturate and zero gives a merged value of 0.
// Write it only while no pixel is in flight.
// Throughput is one pixel per clock while the receiver does not stall. An accepted
// input beat passes through a registered weight ROM read, a lane multiply, the
// lane sum, then a pipelined restoring divider with one quotient bit per stage,
// before it leaves as its output beat.
// Every stage has its own valid bit, so a stalled receiver only holds the stages
// that are full; bubbles collapse and s_axis_tready stays high until the whole
// pipeline is occupied.
// Reset empties the pipeline and sets the exposure count to four.
`default_nettype none
module exposure_fusion_merge_unit #(
	parameter int MAX_EXPOSURES = efm_pkg::MAX_EXPOSURES_DEF,
	parameter int SAMPLE_BITS   = efm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wen,
	input  wire logic [efm_pkg::CFG_BITS-1:0]         cfg_wdata,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// sample_zero, sample_one, sample_two, sample_three, then zero fill
	input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
	input  wire logic                                 s_axis_tlast,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// merged_value, then zero fill
	output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
	output logic                                      m_axis_tlast
);
	import efm_pkg::*;

	localparam int LANES  = (MAX_EXPOSURES < ITEM_LANES) ? MAX_EXPOSURES : ITEM_LANES;
	localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
	localparam int SW_W   = WEIGHT_BITS + $clog2(LANES);
	localparam int VW_W   = PROD_W + $clog2(LANES);
	localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int MV_W   = (SAMPLE_BITS < VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;

	logic [CFG_BITS-1:0]    lanes_cfg_q;
	logic [CFG_BITS-1:0]    lanes_use;
	logic                   v_s1, v_s2, v_s3;
	logic                   last_s1, last_s2, last_s3;
	logic                   rdy1, rdy2, rdy3;
	logic                   div_ready;
	logic [PROD_W-1:0]      prod   [LANES];
	logic [WEIGHT_BITS-1:0] weight [LANES];
	logic [VW_W-1:0]        sum_vw;
	logic [SW_W-1:0]        sum_w;
	logic [SAMPLE_BITS-1:0] quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			lanes_cfg_q <= cfg_wdata;
		end
	end

	assign lanes_use = (lanes_cfg_q > CFG_BITS'(LANES)) ? CFG_BITS'(LANES) : lanes_cfg_q;

	assign rdy3 = !v_s3 || div_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			last_s1 <= s_axis_tlast;
		end
		if (rdy2) begin
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			last_s3 <= last_s2;
		end
	end

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		efm_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk   (clk),
			.en_s1 (rdy1),
			.en_s2 (rdy2),
			.sel   (CFG_BITS'(j) < lanes_use),
			.sample(s_axis_tdata[j*SAMPLE_BITS +: SAMPLE_BITS]),
			.prod  (prod[j]),
			.weight(weight[j])
		);
	end

	efm_merge #(
		.LANES      (LANES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk   (clk),
		.en_s3 (rdy3),
		.prod  (prod),
		.weight(weight),
		.sum_vw(sum_vw),
		.sum_w (sum_w)
	);

	efm_divider #(
		.QUO_W(SAMPLE_BITS),
		.DEN_W(SW_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_ready (div_ready),
		.num      (sum_vw),
		.den      (sum_w),
		.in_last  (last_s3),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.quotient (quotient),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'(quotient[MV_W-1:0]);

endmodule
`default_nettype wire

// ===== sv/efm_lane.sv =====
`default_nettype none
module efm_lane #(
	parameter int SAMPLE_BITS = efm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       en_s1,
	input  wire logic                                       en_s2,
	input  wire logic                                       sel,
	input  wire logic [SAMPLE_BITS-1:0]                     sample,
	output logic      [SAMPLE_BITS+efm_pkg::WEIGHT_BITS-1:0] prod,
	output logic      [efm_pkg::WEIGHT_BITS-1:0]             weight
);
	import efm_pkg::*;

	localparam int DEPTH  = 1 << SAMPLE_BITS;
	localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;

	typedef logic [WEIGHT_BITS-1:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < DEPTH; i++) begin
			r[i] = weight_of(64'(i), SAMPLE_BITS);
		end
		return r;
	endfunction

	localparam rom_t WEIGHT_ROM = build_rom();

	logic [WEIGHT_BITS-1:0] w_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic                   sel_s1;
	logic [PROD_W-1:0]      prod_s2;
	logic [WEIGHT_BITS-1:0] w_s2;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			w_s1   <= WEIGHT_ROM[sample];
			smp_s1 <= sample;
			sel_s1 <= sel;
		end
	end

	// A lane that is not in use contributes nothing to either sum.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= sel_s1 ? PROD_W'(smp_s1) * PROD_W'(w_s1) : '0;
			w_s2    <= sel_s1 ? w_s1 : '0;
		end
	end

	assign prod   = prod_s2;
	assign weight = w_s2;

endmodule
`default_nettype wire

// ===== sv/efm_merge.sv =====
`default_nettype none
module efm_merge #(
	parameter int LANES       = efm_pkg::ITEM_LANES,
	parameter int SAMPLE_BITS = efm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       en_s3,
	input  wire logic [SAMPLE_BITS+efm_pkg::WEIGHT_BITS-1:0] prod [LANES],
	input  wire logic [efm_pkg::WEIGHT_BITS-1:0]             weight [LANES],
	output logic [SAMPLE_BITS+efm_pkg::WEIGHT_BITS+$clog2(LANES)-1:0] sum_vw,
	output logic [efm_pkg::WEIGHT_BITS+$clog2(LANES)-1:0]             sum_w
);
	import efm_pkg::*;

	localparam int VW_W = SAMPLE_BITS + WEIGHT_BITS + $clog2(LANES);
	localparam int SW_W = WEIGHT_BITS + $clog2(LANES);

	logic [VW_W-1:0] vw_acc;
	logic [SW_W-1:0] w_acc;
	logic [VW_W-1:0] sum_vw_s3;
	logic [SW_W-1:0] sum_w_s3;

	always_comb begin
		vw_acc = '0;
		w_acc  = '0;
		for (int j = 0; j < LANES; j++) begin
			vw_acc = vw_acc + VW_W'(prod[j]);
			w_acc  = w_acc + SW_W'(weight[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sum_vw_s3 <= vw_acc;
			sum_w_s3  <= w_acc;
		end
	end

	assign sum_vw = sum_vw_s3;
	assign sum_w  = sum_w_s3;

endmodule
`default_nettype wire

// ===== sv/efm_divider.sv =====
`default_nettype none
module efm_divider #(
	parameter int QUO_W = efm_pkg::SAMPLE_BITS_DEF,
	parameter int DEN_W = efm_pkg::WEIGHT_BITS + 2
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [QUO_W+DEN_W-1:0] num,
	input  wire logic [DEN_W-1:0]       den,
	input  wire logic                   in_last,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [QUO_W-1:0]       quotient,
	output logic                        out_last
);
	import efm_pkg::*;

	localparam int NUM_W = QUO_W + DEN_W;
	localparam int STEPS = QUO_W;

	// One restoring step per stage, most significant quotient bit first.
	// The quotient always fits QUO_W bits since it is an average of samples.
	// Array index of each _s register is the step number.
	logic [NUM_W-1:0] rem_s  [STEPS];
	logic [QUO_W-1:0] quo_s  [STEPS];
	logic [DEN_W-1:0] den_s  [STEPS];
	logic             last_s [STEPS];
	logic             zero_s [STEPS];
	logic             vld_s  [STEPS];
	logic [STEPS:0]   rdy;

	assign rdy[STEPS] = out_ready;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [NUM_W-1:0] src_rem;
		logic [QUO_W-1:0] src_quo;
		logic [DEN_W-1:0] src_den;
		logic             src_last;
		logic             src_zero;
		logic             src_vld;
		logic [NUM_W-1:0] trial;
		logic             take;

		if (k == 0) begin : g_first
			assign src_rem  = num;
			assign src_quo  = '0;
			assign src_den  = den;
			assign src_last = in_last;
			assign src_zero = (den == '0);
			assign src_vld  = in_valid;
		end else begin : g_next
			assign src_rem  = rem_s[k-1];
			assign src_quo  = quo_s[k-1];
			assign src_den  = den_s[k-1];
			assign src_last = last_s[k-1];
			assign src_zero = zero_s[k-1];
			assign src_vld  = vld_s[k-1];
		end

		assign trial  = NUM_W'(src_den) << (STEPS - 1 - k);
		assign take   = (src_rem >= trial);
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k]  <= take ? (src_rem - trial) : src_rem;
				quo_s[k]  <= {src_quo[QUO_W-2:0], take};
				den_s[k]  <= src_den;
				last_s[k] <= src_last;
				zero_s[k] <= src_zero;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[STEPS-1];
	assign out_last  = last_s[STEPS-1];
	// A zero weight sum (no lane in use) yields zero instead of all ones.
	assign quotient  = zero_s[STEPS-1] ? '0 : quo_s[STEPS-1];

endmodule
`default_nettype wire
